### sv/ipid_pkg.sv
// Shared types, widths and register codes for the incremental PID block.
`timescale 1ns / 1ps

package ipid_pkg;

    // Field and intermediate widths
    localparam int SAMPLE_W = 24;   // measurement and setpoints, signed Q16.8
    localparam int GAIN_W   = 16;   // gains, unsigned Q4.12
    localparam int ERR_W    = 25;   // setpoint - measurement
    localparam int DIFF_W   = 27;   // second difference e - 2*e1 + e2
    localparam int FRAC_W   = 12;   // gain fraction bits dropped after each product
    localparam int PROD_W   = GAIN_W + 1 + DIFF_W;
    localparam int TERM_W   = PROD_W - 1 - FRAC_W;
    localparam int DELTA_W  = TERM_W + 2;
    localparam int DRIVE_W  = 18;   // output accumulator, unsigned Q10.8
    localparam int SUM_W    = DELTA_W + 1;
    localparam int CIDX_W   = 3;
    localparam int CDATA_W  = 24;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic        [GAIN_W-1:0]   gain_t;
    typedef logic signed [ERR_W-1:0]    err_t;
    typedef logic signed [DIFF_W-1:0]   diff_t;
    typedef logic signed [PROD_W-1:0]   prod_t;
    typedef logic signed [TERM_W-1:0]   term_t;
    typedef logic signed [DELTA_W-1:0]  delta_t;
    typedef logic signed [SUM_W-1:0]    sum_t;
    typedef logic        [DRIVE_W-1:0]  drive_t;

    // Configuration register indexes
    typedef enum logic [CIDX_W-1:0] {
        CFG_MODE           = 3'd0,
        CFG_SPEED_SETPOINT = 3'd1,
        CFG_ANGLE_SETPOINT = 3'd2,
        CFG_GAIN_P         = 3'd3,
        CFG_GAIN_I         = 3'd4,
        CFG_GAIN_D         = 3'd5
    } cfg_idx_t;

    // Reset values of the configuration registers
    localparam logic    RST_MODE           = 1'b1;
    localparam sample_t RST_SPEED_SETPOINT = 24'sd6400;
    localparam sample_t RST_ANGLE_SETPOINT = 24'sd0;
    localparam gain_t   RST_GAIN_P         = 16'd410;
    localparam gain_t   RST_GAIN_I         = 16'd2048;
    localparam gain_t   RST_GAIN_D         = 16'd2458;

    // Mode codes
    localparam logic MODE_ANGLE = 1'b0;
    localparam logic MODE_SPEED = 1'b1;

endpackage

### sv/ipid_term.sv
// One gain term: unsigned gain times signed difference, floored by the gain fraction.
`timescale 1ns / 1ps

module ipid_term (
    input  ipid_pkg::gain_t gain,
    input  ipid_pkg::diff_t diff,
    output ipid_pkg::term_t term
);

    ipid_pkg::prod_t prod;

    // Multiply with the gain zero-extended so the product stays signed
    assign prod = ipid_pkg::prod_t'($signed({1'b0, gain})) * ipid_pkg::prod_t'(diff);

    // Drop the fraction bits; an arithmetic shift floors toward minus infinity
    assign term = prod[ipid_pkg::PROD_W-2:ipid_pkg::FRAC_W];

endmodule

### sv/incremental_pid_clamped_top.sv
// Top level of the incremental PID controller with clamped output accumulator.
`timescale 1ns / 1ps

// Incremental (velocity-form) PID controller. Each measurement transaction is
// subtracted from the selected setpoint (speed when mode is 1, angle when mode
// is 0) and kp*(e-e1) + ki*e + kd*(e-2*e1+e2) is added to an output accumulator
// clamped to 0..OUTPUT_MAX*256 (Q10.8, top capped at 2^18-1). The block takes one
// measurement per cycle while out_ready holds: a transaction sits in the input
// register, then the three multiplies, the sum and the clamp run in one step that
// writes the error history, the accumulator and the result register together, so
// results come out at a sustained rate of one per cycle unless out_ready stalls.
// That rate is set by the loop through the accumulator and error history
// registers. Configuration writes are always taken and must only be issued while
// no transaction is in flight.
module incremental_pid_clamped_top #(
    parameter int OUTPUT_MAX = 1000
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  ipid_pkg::sample_t                      measurement,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output ipid_pkg::drive_t                       drive_value,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [ipid_pkg::CIDX_W-1:0]            cfg_index,
    input  logic [ipid_pkg::CDATA_W-1:0]           cfg_data
);

    localparam longint LIMIT_FULL = longint'(OUTPUT_MAX) * 256;
    localparam longint LIMIT_CAP  = (longint'(1) << ipid_pkg::DRIVE_W) - 1;
    localparam longint LIMIT_VAL  = (LIMIT_FULL > LIMIT_CAP) ? LIMIT_CAP : LIMIT_FULL;
    localparam ipid_pkg::drive_t ACC_LIMIT = ipid_pkg::DRIVE_W'(LIMIT_VAL);

    // Configuration registers
    logic              mode_reg;
    ipid_pkg::sample_t speed_sp_reg;
    ipid_pkg::sample_t angle_sp_reg;
    ipid_pkg::gain_t   gain_p_reg;
    ipid_pkg::gain_t   gain_i_reg;
    ipid_pkg::gain_t   gain_d_reg;

    // Pipeline and controller state
    logic              s1_valid_reg;
    ipid_pkg::sample_t meas_reg;
    logic              out_valid_reg;
    ipid_pkg::drive_t  drive_reg;
    ipid_pkg::err_t    err_prev_reg;
    ipid_pkg::err_t    err_prev2_reg;
    ipid_pkg::drive_t  accum_reg;
    ipid_pkg::drive_t  accum_next;

    logic              advance;
    ipid_pkg::sample_t setpoint;
    ipid_pkg::err_t    err;
    ipid_pkg::diff_t   diff_p;
    ipid_pkg::diff_t   diff_i;
    ipid_pkg::diff_t   diff_d;
    ipid_pkg::term_t   term_p;
    ipid_pkg::term_t   term_i;
    ipid_pkg::term_t   term_d;
    ipid_pkg::delta_t  delta;
    ipid_pkg::sum_t    acc_sum;

    // Handshake: compute when the result register is free or being drained
    assign advance   = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !s1_valid_reg || advance;
    assign out_valid = out_valid_reg;
    assign drive_value = drive_reg;
    assign cfg_ready = 1'b1;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= ipid_pkg::RST_MODE;
            speed_sp_reg <= ipid_pkg::RST_SPEED_SETPOINT;
            angle_sp_reg <= ipid_pkg::RST_ANGLE_SETPOINT;
            gain_p_reg   <= ipid_pkg::RST_GAIN_P;
            gain_i_reg   <= ipid_pkg::RST_GAIN_I;
            gain_d_reg   <= ipid_pkg::RST_GAIN_D;
        end
        else if (cfg_valid)
        begin
            unique case (ipid_pkg::cfg_idx_t'(cfg_index))
                ipid_pkg::CFG_MODE:           mode_reg     <= cfg_data[0];
                ipid_pkg::CFG_SPEED_SETPOINT: speed_sp_reg <= $signed(cfg_data);
                ipid_pkg::CFG_ANGLE_SETPOINT: angle_sp_reg <= $signed(cfg_data);
                ipid_pkg::CFG_GAIN_P:         gain_p_reg   <= cfg_data[ipid_pkg::GAIN_W-1:0];
                ipid_pkg::CFG_GAIN_I:         gain_i_reg   <= cfg_data[ipid_pkg::GAIN_W-1:0];
                ipid_pkg::CFG_GAIN_D:         gain_d_reg   <= cfg_data[ipid_pkg::GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    // Capture the measurement transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            meas_reg <= measurement;
        end
    end

    // Form the error and the three differences
    always_comb
    begin
        setpoint = (mode_reg == ipid_pkg::MODE_SPEED) ? speed_sp_reg : angle_sp_reg;
        err      = ipid_pkg::err_t'(setpoint) - ipid_pkg::err_t'(meas_reg);
        diff_p   = ipid_pkg::diff_t'(err) - ipid_pkg::diff_t'(err_prev_reg);
        diff_i   = ipid_pkg::diff_t'(err);
        diff_d   = ipid_pkg::diff_t'(err) - (ipid_pkg::diff_t'(err_prev_reg) <<< 1)
                 + ipid_pkg::diff_t'(err_prev2_reg);
    end

    ipid_term u_term_p (.gain(gain_p_reg), .diff(diff_p), .term(term_p));
    ipid_term u_term_i (.gain(gain_i_reg), .diff(diff_i), .term(term_i));
    ipid_term u_term_d (.gain(gain_d_reg), .diff(diff_d), .term(term_d));

    // Sum the terms into the accumulator and clamp
    always_comb
    begin
        delta   = ipid_pkg::delta_t'(term_p) + ipid_pkg::delta_t'(term_i)
                + ipid_pkg::delta_t'(term_d);
        acc_sum = ipid_pkg::sum_t'($signed({1'b0, accum_reg})) + ipid_pkg::sum_t'(delta);
        if (acc_sum < 0)
        begin
            accum_next = '0;
        end
        else if (acc_sum > ipid_pkg::sum_t'($signed({1'b0, ACC_LIMIT})))
        begin
            accum_next = ACC_LIMIT;
        end
        else
        begin
            accum_next = acc_sum[ipid_pkg::DRIVE_W-1:0];
        end
    end

    // Advance controller state and load the result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            err_prev_reg  <= '0;
            err_prev2_reg <= '0;
            accum_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                err_prev2_reg <= err_prev_reg;
                err_prev_reg  <= err;
                accum_reg     <= accum_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            drive_reg <= accum_next;
        end
    end

    // The accumulator never leaves the clamp range
    assert property (@(posedge clk) disable iff (!rst_n) accum_reg <= ACC_LIMIT)
        else $error("accumulator above clamp limit");

    // A computed transaction always shows up as the current result
    assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> (out_valid && drive_value == accum_reg))
        else $error("result register out of step with accumulator");

    // Input stalls only while a transaction waits in the input register
    assert property (@(posedge clk) disable iff (!rst_n) !in_ready |-> s1_valid_reg)
        else $error("input stalled with empty input register");

    // Error history moves only when a transaction is computed
    assert property (@(posedge clk) disable iff (!rst_n)
        !$past(advance) |-> $stable(err_prev_reg) && $stable(accum_reg))
        else $error("controller state changed without a transaction");

endmodule
